>>> rtl/core/twlru_pkg.sv
// ----------------------------------------------------------------------------
// twlru_pkg
// Field widths and counter widths shared by the two-way tag lookup.
// ----------------------------------------------------------------------------
package twlru_pkg;

  localparam int ADDR_W      = 32;
  localparam int OFFSET_OUT_W = 5;
  localparam int BLOCK_OUT_W = 27;
  localparam int SET_OUT_W   = 6;
  localparam int TAG_OUT_W   = 21;
  localparam int COUNT_W     = 32;

  typedef logic [TAG_OUT_W-1:0] tag_t;
  typedef logic [COUNT_W-1:0]   count_t;

endpackage

>>> rtl/core/two_way_lru_cache_tag_lookup.sv
// ----------------------------------------------------------------------------
// two_way_lru_cache_tag_lookup
// Two-way set-associative tag directory with per-set LRU replacement.
// ----------------------------------------------------------------------------
// One byte address is taken per item and one result item comes out for it.
// The block sustains one item per clock cycle while the receiver does not
// stall. Each address is registered in s1_addr, where the tag compare, way
// choice and directory update run; these end in the result register. The
// tag RAMs (one registered-read RAM per way, indexed by the set) are read at
// the edge that accepts the address. A stalled result holds the item behind
// it, so at most two items are in flight. The most recent tag write is held
// and forwarded so that back to back references to one set see each other's
// fills. NUM_SETS and LINE_BYTES must be powers of two. Valid and LRU bits
// live in flip-flops and are cleared by reset; tag RAM contents are only
// read behind a set valid bit.
// ----------------------------------------------------------------------------
module two_way_lru_cache_tag_lookup
  import twlru_pkg::*;
#(
  parameter int NUM_SETS   = 64,
  parameter int LINE_BYTES = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ADDR_W-1:0]       address,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OFFSET_OUT_W-1:0] byte_offset,
  output logic [BLOCK_OUT_W-1:0]  block_number,
  output logic [SET_OUT_W-1:0]    set_index,
  output logic                    way_used,
  output logic [TAG_OUT_W-1:0]    tag_value,
  output logic                    is_miss,
  output logic                    did_replace,
  output logic [TAG_OUT_W-1:0]    evicted_tag,
  output logic [COUNT_W-1:0]      hit_total,
  output logic [COUNT_W-1:0]      miss_total
);

  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int SET_W = $clog2(NUM_SETS);
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'(LINE_BYTES - 1);

  // lookup stage
  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_advance;
  logic              in_accept;

  logic [ADDR_W-1:0] in_block32;
  logic [SET_W-1:0]  in_set;

  logic [ADDR_W-1:0] s1_off32;
  logic [ADDR_W-1:0] s1_block32;
  logic [ADDR_W-1:0] s1_tag32;
  logic [ADDR_W-1:0] s1_set32;
  logic [SET_W-1:0]  s1_set;
  tag_t              s1_tag;

  tag_t              rd_tag0;
  tag_t              rd_tag1;
  tag_t              tag0;
  tag_t              tag1;

  // last tag write, forwarded over the RAM read
  logic              fwd_valid;
  logic [SET_W-1:0]  fwd_set;
  logic              fwd_way;
  tag_t              fwd_tag;

  logic [NUM_SETS-1:0] valid0;
  logic [NUM_SETS-1:0] valid1;
  logic [NUM_SETS-1:0] lru;

  count_t hit_count;
  count_t miss_count;
  count_t hit_count_next;
  count_t miss_count_next;

  logic hit0;
  logic hit1;
  logic hit;
  logic way;
  logic repl;
  tag_t evicted;
  logic wr_en0;
  logic wr_en1;

  assign in_accept  = in_valid && !in_stall;
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  assign in_block32 = address >> OFF_W;
  assign in_set     = in_block32[SET_W-1:0];

  assign s1_off32   = s1_addr & OFF_MASK;
  assign s1_block32 = s1_addr >> OFF_W;
  assign s1_set     = s1_block32[SET_W-1:0];
  assign s1_set32   = {{(ADDR_W-SET_W){1'b0}}, s1_set};
  assign s1_tag32   = s1_block32 >> SET_W;
  assign s1_tag     = s1_tag32[TAG_OUT_W-1:0];

  twlru_ram #(
    .WIDTH (TAG_OUT_W),
    .DEPTH (NUM_SETS)
  ) u_tags0 (
    .clk     (clk),
    .wr_en   (wr_en0),
    .wr_addr (s1_set),
    .wr_data (s1_tag),
    .rd_en   (in_accept),
    .rd_addr (in_set),
    .rd_data (rd_tag0)
  );

  twlru_ram #(
    .WIDTH (TAG_OUT_W),
    .DEPTH (NUM_SETS)
  ) u_tags1 (
    .clk     (clk),
    .wr_en   (wr_en1),
    .wr_addr (s1_set),
    .wr_data (s1_tag),
    .rd_en   (in_accept),
    .rd_addr (in_set),
    .rd_data (rd_tag1)
  );

  always_comb begin
    tag0 = rd_tag0;
    tag1 = rd_tag1;
    if (fwd_valid && (fwd_set == s1_set)) begin
      if (fwd_way) begin
        tag1 = fwd_tag;
      end else begin
        tag0 = fwd_tag;
      end
    end

    hit0 = valid0[s1_set] && (tag0 == s1_tag);
    hit1 = valid1[s1_set] && (tag1 == s1_tag);
    hit  = hit0 || hit1;

    if (hit) begin
      way = !hit0;
    end else if (!valid0[s1_set]) begin
      way = 1'b0;
    end else if (!valid1[s1_set]) begin
      way = 1'b1;
    end else begin
      way = lru[s1_set];
    end

    repl    = !hit && valid0[s1_set] && valid1[s1_set];
    evicted = '0;
    if (repl) begin
      evicted = way ? tag1 : tag0;
    end

    wr_en0 = s1_advance && !hit && !way;
    wr_en1 = s1_advance && !hit && way;

    hit_count_next  = hit ? hit_count + count_t'(1) : hit_count;
    miss_count_next = hit ? miss_count : miss_count + count_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      fwd_valid  <= 1'b0;
      valid0     <= '0;
      valid1     <= '0;
      lru        <= '0;
      hit_count  <= '0;
      miss_count <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
        s1_addr  <= address;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      if (s1_advance) begin
        out_valid    <= 1'b1;
        byte_offset  <= s1_off32[OFFSET_OUT_W-1:0];
        block_number <= s1_block32[BLOCK_OUT_W-1:0];
        set_index    <= s1_set32[SET_OUT_W-1:0];
        way_used     <= way;
        tag_value    <= s1_tag;
        is_miss      <= !hit;
        did_replace  <= repl;
        evicted_tag  <= evicted;
        hit_total    <= hit_count_next;
        miss_total   <= miss_count_next;

        hit_count    <= hit_count_next;
        miss_count   <= miss_count_next;
        lru[s1_set]  <= !way;
        if (!hit) begin
          fwd_valid <= 1'b1;
          fwd_set   <= s1_set;
          fwd_way   <= way;
          fwd_tag   <= s1_tag;
          if (way) begin
            valid1[s1_set] <= 1'b1;
          end else begin
            valid0[s1_set] <= 1'b1;
          end
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_miss |-> !did_replace && (evicted_tag == '0))
    else $error("hit result carries an eviction");

  // the fill rules never leave one tag in both ways
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(hit0 && hit1))
    else $error("tag present in both ways of a set");

  // each item bumps exactly one of the two counters
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> (count_t'(hit_count + miss_count) ==
                    count_t'($past(hit_count) + $past(miss_count) + count_t'(1))))
    else $error("hit and miss counters out of step");

  // a replacement only happens with both ways valid
  a_repl_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && repl |-> valid0[s1_set] && valid1[s1_set] && !hit)
    else $error("replacement in a set with a free way");

  // the LRU bit points away from the way just used
  a_lru_update: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> lru[$past(s1_set)] != $past(way))
    else $error("LRU bit not updated");

endmodule

>>> rtl/core/twlru_ram.sv
// ----------------------------------------------------------------------------
// twlru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read returns the old contents when both ports hit one entry
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-way LRU cache tag lookup. Addresses are fed
// through the valid/stall handshake while a local copy of the tag directory
// predicts hit or miss, the way, any eviction and the running counters for
// each item. Results are checked field by field, in order, under several
// mixes of sender gaps and receiver stalls, with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb
  import twlru_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS        = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int PRINT_LIMIT = 50;

  typedef struct {
    logic [OFFSET_OUT_W-1:0] offset;
    logic [BLOCK_OUT_W-1:0]  block;
    logic [SET_OUT_W-1:0]    set;
    logic                    way;
    tag_t                    tag;
    logic                    miss;
    logic                    replaced;
    tag_t                    evicted;
    count_t                  hits;
    count_t                  misses;
  } lookup_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ADDR_W-1:0]       address = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [OFFSET_OUT_W-1:0] byte_offset;
  logic [BLOCK_OUT_W-1:0]  block_number;
  logic [SET_OUT_W-1:0]    set_index;
  logic                    way_used;
  logic [TAG_OUT_W-1:0]    tag_value;
  logic                    is_miss;
  logic                    did_replace;
  logic [TAG_OUT_W-1:0]    evicted_tag;
  logic [COUNT_W-1:0]      hit_total;
  logic [COUNT_W-1:0]      miss_total;

  two_way_lru_cache_tag_lookup dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .address      (address),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_offset  (byte_offset),
    .block_number (block_number),
    .set_index    (set_index),
    .way_used     (way_used),
    .tag_value    (tag_value),
    .is_miss      (is_miss),
    .did_replace  (did_replace),
    .evicted_tag  (evicted_tag),
    .hit_total    (hit_total),
    .miss_total   (miss_total)
  );

  // Shadow tag directory
  tag_t   way0_tag   [SETS];
  tag_t   way1_tag   [SETS];
  logic   way0_valid [SETS];
  logic   way1_valid [SETS];
  logic   lru_way    [SETS];
  count_t hit_count  = '0;
  count_t miss_count = '0;

  lookup_t expected_lookups[$];
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  int      gap_pct        = 0;
  int      stall_pct      = 0;
  int      hold_requests  = 0;
  int      hold_served    = 0;
  int      hold_left      = 0;
  tag_t    hot_tag [3];
  logic [SET_OUT_W-1:0] hot_set [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic lookup_t look_up_directory(input logic [ADDR_W-1:0] a);
    lookup_t r;
    logic    hit0;
    logic    hit1;
    r.offset   = a[OFFSET_OUT_W-1:0];
    r.block    = a[ADDR_W-1:OFFSET_OUT_W];
    r.set      = a[OFFSET_OUT_W +: SET_OUT_W];
    r.tag      = a[ADDR_W-1 -: TAG_OUT_W];
    r.miss     = 1'b0;
    r.replaced = 1'b0;
    r.evicted  = '0;
    hit0 = way0_valid[r.set] && (way0_tag[r.set] == r.tag);
    hit1 = way1_valid[r.set] && (way1_tag[r.set] == r.tag);
    if (hit0 || hit1) begin
      r.way = !hit0;
      hit_count++;
    end else begin
      r.miss = 1'b1;
      miss_count++;
      if (!way0_valid[r.set]) begin
        r.way = 1'b0;
      end else if (!way1_valid[r.set]) begin
        r.way = 1'b1;
      end else begin
        r.way      = lru_way[r.set];
        r.replaced = 1'b1;
        r.evicted  = r.way ? way1_tag[r.set] : way0_tag[r.set];
      end
      if (r.way) begin
        way1_tag[r.set]   = r.tag;
        way1_valid[r.set] = 1'b1;
      end else begin
        way0_tag[r.set]   = r.tag;
        way0_valid[r.set] = 1'b1;
      end
    end
    lru_way[r.set] = !r.way;
    r.hits   = hit_count;
    r.misses = miss_count;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("tb: t=%0t %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  // Predict on accepted addresses, check on accepted results (results first,
  // as a result can never belong to an item accepted at the same edge)
  always @(posedge clk) begin
    lookup_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_lookups.pop_front();
        check_field("byte_offset",  byte_offset,  e.offset);
        check_field("block_number", block_number, e.block);
        check_field("set_index",    set_index,    e.set);
        check_field("way_used",     way_used,     e.way);
        check_field("tag_value",    tag_value,    e.tag);
        check_field("is_miss",      is_miss,      e.miss);
        check_field("did_replace",  did_replace,  e.replaced);
        check_field("evicted_tag",  evicted_tag,  e.evicted);
        check_field("hit_total",    hit_total,    e.hits);
        check_field("miss_total",   miss_total,   e.misses);
      end
    end
    if (!rst && in_valid && !in_stall) expected_lookups.push_back(look_up_directory(address));
  end

  function automatic logic [ADDR_W-1:0] ref_addr(input tag_t t,
                                                 input logic [SET_OUT_W-1:0] s,
                                                 input logic [OFFSET_OUT_W-1:0] o);
    return {t, s, o};
  endfunction

  // Offer one item, with random gaps before it; return once it is taken
  task automatic send_ref(input logic [ADDR_W-1:0] a);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    address  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Let the last accepted item reach the queue before watching it empty
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic refresh_hot_pool();
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(5))
        0:       hot_tag[i] = '0;
        1:       hot_tag[i] = '1;
        default: hot_tag[i] = TAG_OUT_W'($urandom());
      endcase
    end
    for (int i = 0; i < 4; i++) hot_set[i] = SET_OUT_W'($urandom());
  endtask

  // Mostly references that revisit a few tags, mostly in a few sets, so that
  // hits, fills and LRU evictions all recur; a fifth is fully random
  function automatic logic [ADDR_W-1:0] pick_ref();
    int unsigned r;
    logic [SET_OUT_W-1:0] s;
    r = $urandom_range(99);
    if (r < 20) return $urandom();
    s = (r < 80) ? hot_set[$urandom_range(3)] : SET_OUT_W'($urandom());
    return ref_addr(hot_tag[$urandom_range(2)], s, OFFSET_OUT_W'($urandom()));
  endfunction

  task automatic test_fill_hit_evict();
    tag_t ta;
    tag_t tb_;
    tag_t tc;
    logic [SET_OUT_W-1:0] s;
    ta  = '0;
    tb_ = '1;
    tc  = 21'h0AAAAA;
    s   = 6'd5;
    gap_pct   = 0;
    stall_pct = 0;
    // address extremes, then hits on them with the other offset extreme
    send_ref('0);
    send_ref('1);
    send_ref(ref_addr('0, '0, '1));
    send_ref(ref_addr('1, '1, '0));
    // fill both ways, then walk the LRU through evictions in one set
    send_ref(ref_addr(ta, s, 5'd3));
    send_ref(ref_addr(tb_, s, 5'd0));
    send_ref(ref_addr(ta, s, 5'd7));
    send_ref(ref_addr(tc, s, 5'd1));
    send_ref(ref_addr(tb_, s, 5'd2));
    send_ref(ref_addr(tc, s, 5'd31));
    send_ref(ref_addr(ta, s, 5'd0));
    send_ref(ref_addr(ta, s, 5'd0));
    send_ref(ref_addr(tb_, s + 6'd1, 5'd0));
    send_ref(ref_addr(tc, s, 5'd16));
    // evict a valid line whose tag is zero
    send_ref(ref_addr('0, '1, 5'd9));
    send_ref(ref_addr('1, '1, 5'd9));
    send_ref(ref_addr(21'h155555, '1, 5'd9));
    send_ref(ref_addr('0, '1, 5'd9));
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input int gaps, input int stalls);
    gap_pct   = gaps;
    stall_pct = stalls;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) refresh_hot_pool();
      send_ref(pick_ref());
    end
    drain_results();
  endtask

  // Receiver holds off for a long stretch while addresses keep coming
  task automatic test_back_pressure();
    gap_pct   = 0;
    stall_pct = 0;
    hold_requests++;
    refresh_hot_pool();
    for (int i = 0; i < 120; i++) send_ref(pick_ref());
    drain_results();
  endtask

  // Sender pauses until every result is out, then resumes
  task automatic test_pause_and_resume();
    gap_pct   = 20;
    stall_pct = 20;
    refresh_hot_pool();
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 20; i++) send_ref(pick_ref());
      drain_results();
    end
  endtask

  initial begin
    for (int i = 0; i < SETS; i++) begin
      way0_tag[i]   = '0;
      way1_tag[i]   = '0;
      way0_valid[i] = 1'b0;
      way1_valid[i] = 1'b0;
      lru_way[i]    = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_hit_evict();
    test_random_traffic(450, 0, 0);
    test_random_traffic(450, 47, 0);
    test_random_traffic(450, 0, 47);
    test_random_traffic(450, 34, 34);
    test_back_pressure();
    test_pause_and_resume();

    gap_pct   = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_lookups.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
